[rtl/tcw_pkg.sv]
// shared types and constants of the text console writer
package tcw_pkg;

    // op codes of an input word
    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // character codes and register reset
    localparam logic [7:0] NEWLINE_CODE = 8'd10;
    localparam logic [7:0] SPACE_CODE   = 8'd32;
    localparam logic [4:0] SCROLL_RESET = 5'd3;

    // widest cell address over the whole parameter range (128 x 256 cells)
    localparam int ADDR_MAX_W = 15;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // input word
    typedef struct packed {
        logic [1:0] op;
        logic [7:0] char_code;
        logic [4:0] read_row;
        logic [6:0] read_col;
    } t_in;

    // result word
    typedef struct packed {
        logic [7:0] cell_value;
        logic [6:0] cursor_col;
        logic [4:0] cursor_row;
        logic       scrolled;
    } t_rsp;

    // classified command
    typedef enum logic [2:0] {
        K_PUT,
        K_NEWLINE,
        K_CLEAR,
        K_READ,
        K_NOP
    } t_kind;

    typedef struct packed {
        t_kind                 kind;
        logic [7:0]            ch;
        logic [ADDR_MAX_W-1:0] addr;
    } t_cmd;

endpackage

[rtl/tcw_chan_if.sv]
// valid/ready channel carrying one word of a given type
interface tcw_chan_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[rtl/text_console_writer.sv]
// top level of the text console writer
// A ROWS x COLUMNS character grid held in one single-port-write, registered-read
// memory, with a cursor. Input words pass a classifying front end and a
// two-entry queue to the back end. After reset the back end clears the grid one
// cell a cycle and takes no input word while it does so. A put or newline is
// handled in the cycle it is taken; an in-range read passes through the read
// state for the registered memory read. A clear and a put that scrolls both run
// the one-cell-a-cycle sweep of the grid memory; the result of a clear comes out
// at its start, that of a scroll at its end. A result that waits to be taken
// holds the back end from starting the next word, while the queue goes on taking
// up to two words; a clear sweep runs on while its result waits. scroll_lines is
// written on its own channel, which is always ready.
module text_console_writer import tcw_pkg::*; #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 20
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tcw_chan_if.sink    i_cmd,
    tcw_chan_if.source  o_rsp,
    tcw_chan_if.sink    i_cfg
);

    logic [4:0] r_scroll_lines;
    logic       w_init;

    tcw_chan_if #(.T(t_cmd)) q_in ();
    tcw_chan_if #(.T(t_cmd)) q_out ();

    // scroll amount register
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scroll_lines <= SCROLL_RESET;
        end else if (i_cfg.valid) begin
            r_scroll_lines <= i_cfg.data;
        end
    end

    // front end
    tcw_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .i_hold (w_init),
        .i_in   (i_cmd),
        .o_cmd  (q_in)
    );

    // command queue
    tcw_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_in),
        .o_pop   (q_out)
    );

    // back end
    tcw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_scroll_lines (r_scroll_lines),
        .i_cmd          (q_out),
        .o_rsp          (o_rsp),
        .o_init         (w_init)
    );

    // no word taken while the grid is cleared after reset
    a_init_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_init |-> !i_cmd.ready)
        else $error("input word taken during initial clear");

    // no result can exist before the first word is processed
    a_init_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_init |-> !o_rsp.valid)
        else $error("result offered during initial clear");

    // a scroll always leaves the cursor at column zero
    a_scroll_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.data.scrolled) |-> (o_rsp.data.cursor_col == 7'd0))
        else $error("scroll result with cursor off column zero");

    // the reported cursor row stays inside the grid
    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (o_rsp.data.cursor_row < ROWS))
        else $error("cursor row outside the grid");

endmodule

[rtl/tcw_front.sv]
// front end: takes input words, classifies them and works out read addresses
module tcw_front import tcw_pkg::*; #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 20
) (
    input  logic        i_hold,
    tcw_chan_if.sink    i_in,
    tcw_chan_if.source  o_cmd
);

    logic [15:0] lin_addr;
    logic        in_range;
    t_cmd        cmd;

    // linear cell address and bounds check of a read
    always_comb begin
        lin_addr = 16'(i_in.data.read_row) * 16'(COLUMNS) + 16'(i_in.data.read_col);
        in_range = ({3'b000, i_in.data.read_row} < 8'(ROWS)) &&
                   ({2'b00, i_in.data.read_col} < 9'(COLUMNS));
    end

    // classify the word
    always_comb begin
        cmd.ch   = i_in.data.char_code;
        cmd.addr = lin_addr[ADDR_MAX_W-1:0];
        case (i_in.data.op)
            OP_PUT: begin
                cmd.kind = (i_in.data.char_code == NEWLINE_CODE) ? K_NEWLINE : K_PUT;
            end
            OP_CLEAR: begin
                cmd.kind = K_CLEAR;
            end
            OP_READ: begin
                cmd.kind = in_range ? K_READ : K_NOP;
            end
            default: begin
                cmd.kind = K_NOP;
            end
        endcase
    end

    // handshake, held off while the grid is cleared after reset
    assign o_cmd.valid = i_in.valid && !i_hold;
    assign o_cmd.data  = cmd;
    assign i_in.ready  = o_cmd.ready && !i_hold;

endmodule

[rtl/tcw_cmd_fifo.sv]
// short command queue between front and back
module tcw_cmd_fifo import tcw_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tcw_chan_if.sink    i_push,
    tcw_chan_if.source  o_pop
);

    t_cmd              r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QCNT_W-1:0] r_cnt;
    logic              push;
    logic              pop;

    assign i_push.ready = (r_cnt != QCNT_W'(QUEUE_DEPTH));
    assign o_pop.valid  = (r_cnt != '0);
    assign o_pop.data   = r_q[r_rp];
    assign push         = i_push.valid && i_push.ready;
    assign pop          = o_pop.valid && o_pop.ready;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wp + QPTR_W'(1);
            end
            if (pop) begin
                r_rp <= (r_rp == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rp + QPTR_W'(1);
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + QCNT_W'(1);
            end else if (pop && !push) begin
                r_cnt <= r_cnt - QCNT_W'(1);
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= i_push.data;
        end
    end

endmodule

[rtl/tcw_back.sv]
// back end: grid memory, cursor, clear and scroll sequencer, result register
module tcw_back import tcw_pkg::*; #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 20
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [4:0]  i_scroll_lines,
    tcw_chan_if.sink    i_cmd,
    tcw_chan_if.source  o_rsp,
    output logic        o_init
);

    localparam int N      = ROWS * COLUMNS;
    localparam int ADDR_W = $clog2(N);
    localparam int CNT_W  = $clog2(N + 1);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);

    typedef enum logic [4:0] {
        S_CLEAR  = 5'b00001,
        S_IDLE   = 5'b00010,
        S_READ   = 5'b00100,
        S_SCROLL = 5'b01000,
        S_DRAIN  = 5'b10000
    } t_state;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_idx, n_idx;
    logic [CNT_W-1:0]  r_shift, n_shift;
    logic [CNT_W-1:0]  r_keep, n_keep;
    logic              r_init, n_init;
    logic              r_drain_rsp, n_drain_rsp;
    logic [COL_W-1:0]  r_cur_x, n_cur_x;
    logic [ROW_W-1:0]  r_cur_y, n_cur_y;
    logic [ADDR_W-1:0] r_row_base, n_row_base;
    logic [ADDR_W-1:0] r_cur_addr, n_cur_addr;
    logic              r_wv, n_wv;
    logic [ADDR_W-1:0] r_wa, n_wa;
    logic              r_wcopy, n_wcopy;
    logic [7:0]        r_wd, n_wd;
    logic [7:0]        r_mem [N];
    logic [7:0]        r_rd_data;
    logic              r_ov;
    t_rsp              r_rsp;

    t_cmd              cmd;
    logic              out_free;
    logic              take;
    logic              wrap;
    logic              last_row;
    logic [7:0]        cfg8;
    logic [7:0]        amt;
    logic [7:0]        keep_rows;
    logic [CNT_W-1:0]  ra_sum;
    logic [ADDR_W-1:0] mem_ra;
    logic              put_we;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_wa;
    logic [7:0]        mem_wd;
    logic              load;
    t_rsp              load_rsp;

    assign cmd         = i_cmd.data;
    assign out_free    = !r_ov || o_rsp.ready;
    assign i_cmd.ready = (r_state == S_IDLE) && out_free;
    assign take        = i_cmd.valid && i_cmd.ready;

    // cursor edge conditions and clamped scroll amount
    always_comb begin
        wrap      = (cmd.kind == K_NEWLINE) || (r_cur_x == COL_W'(COLUMNS - 1));
        last_row  = (r_cur_y == ROW_W'(ROWS - 1));
        cfg8      = {3'b000, i_scroll_lines};
        if (cfg8 == 8'd0) begin
            amt = 8'd1;
        end else if (cfg8 > 8'(ROWS)) begin
            amt = 8'(ROWS);
        end else begin
            amt = cfg8;
        end
        keep_rows = 8'(ROWS) - amt;
        ra_sum    = r_idx + r_shift;
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_shift     = r_shift;
        n_keep      = r_keep;
        n_init      = r_init;
        n_drain_rsp = r_drain_rsp;
        n_cur_x     = r_cur_x;
        n_cur_y     = r_cur_y;
        n_row_base  = r_row_base;
        n_cur_addr  = r_cur_addr;
        n_wv        = 1'b0;
        n_wa        = r_wa;
        n_wcopy     = r_wcopy;
        n_wd        = r_wd;
        mem_ra      = cmd.addr[ADDR_W-1:0];
        put_we      = 1'b0;
        load        = 1'b0;
        load_rsp    = '0;
        case (r_state)
            S_IDLE: begin
                if (take) begin
                    case (cmd.kind)
                        K_PUT, K_NEWLINE: begin
                            put_we = (cmd.kind == K_PUT);
                            if (!wrap) begin
                                n_cur_x    = r_cur_x + COL_W'(1);
                                n_cur_addr = r_cur_addr + ADDR_W'(1);
                                load       = 1'b1;
                            end else if (!last_row) begin
                                n_cur_x    = '0;
                                n_cur_y    = r_cur_y + ROW_W'(1);
                                n_row_base = r_row_base + ADDR_W'(COLUMNS);
                                n_cur_addr = r_row_base + ADDR_W'(COLUMNS);
                                load       = 1'b1;
                            end else begin
                                // past the bottom: start the grid copy
                                n_shift     = CNT_W'(amt * COLUMNS);
                                n_keep      = CNT_W'(keep_rows * COLUMNS);
                                n_cur_x     = '0;
                                n_cur_y     = ROW_W'(keep_rows);
                                n_row_base  = n_keep[ADDR_W-1:0];
                                n_cur_addr  = n_keep[ADDR_W-1:0];
                                n_idx       = '0;
                                n_drain_rsp = 1'b1;
                                n_state     = S_SCROLL;
                            end
                        end
                        K_CLEAR: begin
                            load        = 1'b1;
                            n_idx       = '0;
                            n_drain_rsp = 1'b0;
                            n_state     = S_CLEAR;
                        end
                        K_READ: begin
                            n_state = S_READ;
                        end
                        default: begin
                            load = 1'b1;
                        end
                    endcase
                end
            end
            S_READ: begin
                load                = 1'b1;
                load_rsp.cell_value = r_rd_data;
                n_state             = S_IDLE;
            end
            S_CLEAR, S_SCROLL: begin
                // one cell a cycle, written next cycle: read data or a fill
                n_wv    = 1'b1;
                n_wa    = r_idx[ADDR_W-1:0];
                n_wcopy = (r_state == S_SCROLL) && (r_idx < r_keep);
                n_wd    = (r_state == S_SCROLL) ? SPACE_CODE : 8'd0;
                mem_ra  = ra_sum[ADDR_W-1:0];
                n_idx   = r_idx + CNT_W'(1);
                if (r_idx == CNT_W'(N - 1)) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_IDLE;
                n_init  = 1'b0;
                if (r_drain_rsp) begin
                    load              = 1'b1;
                    load_rsp.scrolled = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        load_rsp.cursor_col = 7'(n_cur_x);
        load_rsp.cursor_row = 5'(n_cur_y);
    end

    // memory write port: sweep stage or a put
    always_comb begin
        mem_we = r_wv || put_we;
        mem_wa = r_wv ? r_wa : r_cur_addr;
        mem_wd = r_wv ? (r_wcopy ? r_rd_data : r_wd) : cmd.ch;
    end

    // grid memory with registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd_data <= r_mem[mem_ra];
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_idx       <= '0;
            r_init      <= 1'b1;
            r_drain_rsp <= 1'b0;
            r_cur_x     <= '0;
            r_cur_y     <= '0;
            r_row_base  <= '0;
            r_cur_addr  <= '0;
            r_wv        <= 1'b0;
            r_ov        <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_init      <= n_init;
            r_drain_rsp <= n_drain_rsp;
            r_cur_x     <= n_cur_x;
            r_cur_y     <= n_cur_y;
            r_row_base  <= n_row_base;
            r_cur_addr  <= n_cur_addr;
            r_wv        <= n_wv;
            if (load) begin
                r_ov <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_shift <= n_shift;
        r_keep  <= n_keep;
        r_wa    <= n_wa;
        r_wcopy <= n_wcopy;
        r_wd    <= n_wd;
        if (load) begin
            r_rsp <= load_rsp;
        end
    end

    assign o_rsp.valid = r_ov;
    assign o_rsp.data  = r_rsp;
    assign o_init      = r_init;

endmodule

[tb/tb.sv]
// self-checking testbench of the text console writer: predictor, random stimulus, checks
module tb;
    import tcw_pkg::*;

    localparam int CON_COLS       = 80;
    localparam int CON_ROWS       = 20;
    localparam int PHASES         = 6;
    localparam int WORDS_PER_PHASE = 272;
    localparam int HOLD_CYCLES    = 64;
    // watchdog limit, set above the length of a grid sweep (clear, scroll or reset clear)
    localparam int QUIET_LIMIT    = 8000;
    localparam int TAIL_CYCLES    = 20;
    // op code the block leaves unused
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // idling modes of a phase
    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle;

    // predicts the console grid and cursor, holds the results still to come
    class console_scoreboard;
        logic [7:0] grid [CON_ROWS][CON_COLS];
        int         cur_col;
        int         cur_row;
        logic [4:0] scroll_reg;
        t_rsp       expected [$];
        int         errors;
        int         n_words;
        int         n_puts;
        int         n_reads;
        int         n_clears;
        int         n_scrolls;

        function new();
            foreach (grid[r, c]) grid[r][c] = 8'd0;
            cur_col    = 0;
            cur_row    = 0;
            scroll_reg = SCROLL_RESET;
            errors     = 0;
            n_words    = 0;
            n_puts     = 0;
            n_reads    = 0;
            n_clears   = 0;
            n_scrolls  = 0;
        endfunction

        function int pending();
            return expected.size();
        endfunction

        // move the grid up and blank the freed rows with spaces
        function void scroll_up();
            int amt;
            amt = (scroll_reg == 5'd0) ? 1 : int'(scroll_reg);
            if (amt > CON_ROWS) amt = CON_ROWS;
            for (int r = amt; r < CON_ROWS; r++) grid[r - amt] = grid[r];
            for (int r = CON_ROWS - amt; r < CON_ROWS; r++) begin
                for (int c = 0; c < CON_COLS; c++) grid[r][c] = SPACE_CODE;
            end
            cur_row = CON_ROWS - amt;
            cur_col = 0;
        endfunction

        // an input word was taken: work out its result
        function void note_word(t_in w);
            t_rsp exp;
            exp = '0;
            n_words++;
            case (w.op)
                OP_PUT: begin
                    n_puts++;
                    if (w.char_code == NEWLINE_CODE) begin
                        cur_col = 0;
                        cur_row++;
                    end else begin
                        grid[cur_row][cur_col] = w.char_code;
                        cur_col++;
                        if (cur_col >= CON_COLS) begin
                            cur_col = 0;
                            cur_row++;
                        end
                    end
                    if (cur_row >= CON_ROWS) begin
                        scroll_up();
                        exp.scrolled = 1'b1;
                        n_scrolls++;
                    end
                end
                OP_CLEAR: begin
                    n_clears++;
                    foreach (grid[r, c]) grid[r][c] = 8'd0;
                end
                OP_READ: begin
                    n_reads++;
                    if (w.read_row < CON_ROWS && w.read_col < CON_COLS)
                        exp.cell_value = grid[w.read_row][w.read_col];
                end
                default: ;
            endcase
            exp.cursor_col = 7'(cur_col);
            exp.cursor_row = 5'(cur_row);
            expected.push_back(exp);
        endfunction

        function void report(string field, logic [7:0] want, logic [7:0] seen);
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, seen);
            errors++;
        endfunction

        // a result word was taken: compare it with the oldest prediction
        function void check_result(t_rsp got);
            t_rsp exp;
            if (expected.size() == 0) begin
                $display("%0t: result with nothing expected, got %p", $time, got);
                errors++;
                return;
            end
            exp = expected.pop_front();
            if (got.cell_value !== exp.cell_value)
                report("cell_value", exp.cell_value, got.cell_value);
            if (got.cursor_col !== exp.cursor_col)
                report("cursor_col", 8'(exp.cursor_col), 8'(got.cursor_col));
            if (got.cursor_row !== exp.cursor_row)
                report("cursor_row", 8'(exp.cursor_row), 8'(got.cursor_row));
            if (got.scrolled !== exp.scrolled)
                report("scrolled", 8'(exp.scrolled), 8'(got.scrolled));
        endfunction
    endclass

    logic  i_clk = 1'b0;
    logic  i_rst_n;
    t_idle idle_mode = IDLE_NONE;
    bit    hold_req = 1'b0;
    int    quiet_cycles = 0;
    console_scoreboard sb;

    tcw_chan_if #(.T(t_in))        cmd ();
    tcw_chan_if #(.T(t_rsp))       rsp ();
    tcw_chan_if #(.T(logic [4:0])) cfg ();

    text_console_writer #(
        .COLUMNS(CON_COLS),
        .ROWS   (CON_ROWS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (cmd),
        .o_rsp  (rsp),
        .i_cfg  (cfg)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic bit percent_hit(int pct);
        return $urandom_range(99) < pct;
    endfunction

    function automatic t_in make_word(logic [1:0] op, logic [7:0] ch,
                                      logic [4:0] row, logic [6:0] col);
        t_in w;
        w.op        = op;
        w.char_code = ch;
        w.read_row  = row;
        w.read_col  = col;
        return w;
    endfunction

    // mostly text with line breaks and reads, the odd clear and unused op
    function automatic t_in random_word();
        t_in w;
        int  pick;
        w    = make_word(OP_PUT, 8'($urandom), 5'($urandom), 7'($urandom));
        pick = $urandom_range(99);
        if (pick < 55) begin
            w.char_code = 8'($urandom_range(126, 32));
        end else if (pick < 62) begin
            w.char_code = 8'($urandom_range(255));
        end else if (pick < 70) begin
            w.char_code = NEWLINE_CODE;
        end else if (pick < 71) begin
            w.op = OP_CLEAR;
        end else if (pick < 73) begin
            w.op = OP_UNUSED;
        end else begin
            w.op = OP_READ;
            if (percent_hit(85)) begin
                w.read_row = 5'($urandom_range(CON_ROWS - 1));
                w.read_col = 7'($urandom_range(CON_COLS - 1));
            end
        end
        return w;
    endfunction

    function automatic bit sender_waits();
        case (idle_mode)
            IDLE_SENDER: return percent_hit(84);
            IDLE_BOTH:   return percent_hit(19);
            default:     return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_stalls();
        case (idle_mode)
            IDLE_RECEIVER: return percent_hit(84);
            IDLE_BOTH:     return percent_hit(19);
            default:       return 1'b0;
        endcase
    endfunction

    // offer one word, valid stays high after it is taken
    task automatic send_word(input t_in w);
        while (sender_waits()) begin
            cmd.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd.valid <= 1'b1;
        cmd.data  <= w;
        @(posedge i_clk);
        while (!cmd.ready) @(posedge i_clk);
        sb.note_word(w);
    endtask

    task automatic write_scroll(input logic [4:0] lines);
        cfg.valid <= 1'b1;
        cfg.data  <= lines;
        @(posedge i_clk);
        while (!cfg.ready) @(posedge i_clk);
        cfg.valid <= 1'b0;
        sb.scroll_reg = lines;
    endtask

    // stop offering and wait for every predicted result
    task automatic drain();
        cmd.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // result side: take words, stall at random, one long hold-off on request
    initial begin : rsp_side
        int hold_left;
        hold_left = 0;
        rsp.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rsp.valid && rsp.ready) sb.check_result(rsp.data);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (!i_rst_n || hold_left > 0) begin
                if (hold_left > 0) hold_left--;
                rsp.ready <= 1'b0;
            end else begin
                rsp.ready <= !receiver_stalls();
            end
        end
    end

    // watchdog on cycles with no word moving on any channel
    always @(posedge i_clk) begin
        if ((cmd.valid && cmd.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
                $display("tb: FAIL");
                $finish;
            end
        end
    end

    // main sequence
    initial begin : stimulus
        t_in        opening [$];
        logic [4:0] scroll_plan [PHASES];
        sb          = new();
        scroll_plan = '{SCROLL_RESET, 5'd1, 5'd20, 5'd0, 5'd31, 5'd12};
        i_rst_n   <= 1'b0;
        cmd.valid <= 1'b0;
        cmd.data  <= '0;
        cfg.valid <= 1'b0;
        cfg.data  <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // corners, every op, out-of-range reads, unused op, clear keeping the cursor
        opening.push_back(make_word(OP_READ, 8'hFF, 5'd0, 7'd0));
        opening.push_back(make_word(OP_PUT, 8'h00, 5'd0, 7'd0));
        opening.push_back(make_word(OP_PUT, 8'hFF, 5'd31, 7'd127));
        opening.push_back(make_word(OP_PUT, 8'h41, 5'd0, 7'd0));
        opening.push_back(make_word(OP_READ, 8'h00, 5'd0, 7'd1));
        opening.push_back(make_word(OP_READ, 8'h00, 5'd0, 7'd0));
        opening.push_back(make_word(OP_PUT, NEWLINE_CODE, 5'd0, 7'd0));
        opening.push_back(make_word(OP_UNUSED, 8'hFF, 5'd31, 7'd127));
        opening.push_back(make_word(OP_PUT, 8'h7F, 5'd0, 7'd0));
        opening.push_back(make_word(OP_READ, 8'h00, 5'd1, 7'd0));
        opening.push_back(make_word(OP_READ, 8'h00, 5'd19, 7'd79));
        opening.push_back(make_word(OP_READ, 8'h00, 5'd20, 7'd0));
        opening.push_back(make_word(OP_READ, 8'h00, 5'd0, 7'd80));
        opening.push_back(make_word(OP_READ, 8'hFF, 5'd31, 7'd127));
        opening.push_back(make_word(OP_CLEAR, 8'hFF, 5'd31, 7'd127));
        opening.push_back(make_word(OP_READ, 8'h00, 5'd0, 7'd1));
        opening.push_back(make_word(OP_PUT, SPACE_CODE, 5'd0, 7'd0));
        opening.push_back(make_word(OP_READ, 8'h00, 5'd1, 7'd1));

        for (int ph = 0; ph < PHASES; ph++) begin
            idle_mode = t_idle'(ph % 4);
            if (ph != 0) write_scroll(scroll_plan[ph]);
            if (ph == 0) begin
                foreach (opening[i]) send_word(opening[i]);
                // long receiver hold-off while words keep coming
                hold_req = 1'b1;
            end
            for (int k = 0; k < WORDS_PER_PHASE; k++) send_word(random_word());
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("run: %0d words, %0d puts, %0d reads, %0d clears, %0d scrolls",
                 sb.n_words, sb.n_puts, sb.n_reads, sb.n_clears, sb.n_scrolls);
        $display("run: scroll settings 3, 1, 20, 0, 31, 12 under four idling modes");
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("%0t: %0d errors, %0d results missing", $time, sb.errors, sb.pending());
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/tcw_pkg.sv
rtl/tcw_chan_if.sv
rtl/tcw_front.sv
rtl/tcw_cmd_fifo.sv
rtl/tcw_back.sv
rtl/text_console_writer.sv
tb/tb.sv
